// ===== design/waveshaping_distortion_top_macros.svh =====
// assertion helpers for the waveshaper design files
// each helper is clocked on clk and switched off while rst_n is low
`ifndef WAVESHAPING_DISTORTION_TOP_MACROS_SVH
`define WAVESHAPING_DISTORTION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define WSD_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("wsd check failed");
`define WSD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsd check failed");
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsd check failed");
`else
`define WSD_ASSERT(lbl, expr)
`define WSD_ASSERT_IMPLY(lbl, ante, cons)
`define WSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/wsd_pkg.sv =====
package wsd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int D_W      = 20;
    localparam int THR_W    = 15;
    localparam int GAIN_W   = 16;
    localparam int MIX_W    = 7;
    localparam int MODE_W   = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN = 3'd4;

    localparam logic [MODE_W-1:0] MODE_SOFT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HARD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FOLD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd3;

    localparam int UNITY_GAIN = 4096;
    localparam int ROUND_Q12  = 2048;
    localparam int MIX_FULL   = 100;
    localparam int T_ONE      = 32768;

    // tanh continued-fraction coefficients, constant term already in q12
    localparam int TANH_K0 = 553512960;
    localparam int TANH_N1 = 17325;
    localparam int TANH_N2 = 378;
    localparam int TANH_D1 = 62370;
    localparam int TANH_D2 = 3150;
    localparam int TANH_D3 = 28;

    // ceil(2^30 / 100), exact floor division by 100 for values below 2^23
    localparam int RECIP_100 = 10737419;
    localparam int SAT_SPAN  = 3276800;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int DIV1_W     = 30;
    localparam int DIV1_VW    = 17;
    localparam int DIV1_STEPS = 30;
    localparam int DIV2_VW    = 35;
    localparam int DIV2_STEPS = 16;

    typedef enum logic [1:0] {
        CLS_SOFT,
        CLS_HARD,
        CLS_FOLD,
        CLS_MUTE
    } cls_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [GAIN_W-1:0] drive;
        logic [THR_W-1:0]  thr;
        logic [MIX_W-1:0]  mix;
        logic [GAIN_W-1:0] og;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [D_W-1:0]      d;
        cls_t                       cls;
    } item_t;

endpackage

// ===== design/waveshaping_distortion_top.sv =====
// Waveshaper: each item on the input channel is one signed q1.15 sample and gives exactly one
// blended, saturated q1.15 sample on the output channel, in order. The block takes one item per
// clock while in_stall is low; an accepted item waits in the front queue and then passes through
// the 58 back pipeline stages, most of them in the two restoring dividers of the back end, the
// 30-stage soft/fold divider and the 16-stage tanh quotient divider, each resolving one bit per
// stage. A 4-entry queue decouples the front from the back: in_stall rises only when it is full,
// and out_stall with a result waiting freezes the whole back pipeline. Registers are written with
// cfg_write, cfg_index and cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce. A zero threshold is stored as one and a mix above one hundred as
// one hundred, an index beyond output_gain is ignored, and mode 3 gives zero samples.
module waveshaping_distortion_top
    import wsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    logic [MODE_W-1:0] mode_reg;
    logic [GAIN_W-1:0] drive_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [MIX_W-1:0]  mix_reg;
    logic [GAIN_W-1:0] og_reg;
    cfg_t              cfg;

    // front to queue
    logic  push;
    item_t item;
    // queue to back
    logic  pop;
    item_t head;
    logic  full;
    logic  empty;

    // configuration registers, clamped on write so the datapath sees legal values only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SOFT;
            drive_reg <= GAIN_W'(UNITY_GAIN);
            thr_reg   <= {THR_W{1'b1}};
            mix_reg   <= MIX_W'(MIX_FULL);
            og_reg    <= GAIN_W'(UNITY_GAIN);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:     mode_reg  <= cfg_data[MODE_W-1:0];
                REG_DRIVE:    drive_reg <= cfg_data;
                // zero threshold acts as one
                REG_THRESH:   thr_reg   <= (cfg_data[THR_W-1:0] == '0) ? THR_W'(1)
                                                                        : cfg_data[THR_W-1:0];
                // wet share tops out at a hundred percent
                REG_MIX:      mix_reg   <= (cfg_data[MIX_W-1:0] > MIX_W'(MIX_FULL))
                                           ? MIX_W'(MIX_FULL) : cfg_data[MIX_W-1:0];
                REG_OUT_GAIN: og_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign cfg.mode  = mode_reg;
    assign cfg.drive = drive_reg;
    assign cfg.thr   = thr_reg;
    assign cfg.mix   = mix_reg;
    assign cfg.og    = og_reg;

    // front: drive gain and shape class per item
    wsd_front u_front (
        .in_valid  (in_valid),
        .sample_in (sample_in),
        .cfg       (cfg),
        .full      (full),
        .in_stall  (in_stall),
        .push      (push),
        .item      (item)
    );

    // short queue between front and back
    wsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .pop   (pop),
        .head  (head),
        .full  (full),
        .empty (empty)
    );

    // back: shaping, output gain, dry/wet blend and saturation
    wsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule

// ===== design/wsd_front.sv =====
module wsd_front
    import wsd_pkg::*;
(
    input  logic                       in_valid,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  cfg_t                       cfg,
    input  logic                       full,
    output logic                       in_stall,
    output logic                       push,
    output item_t                      item
);

    logic signed [32:0] drv_prod;
    logic signed [32:0] drv_sum;
    cls_t               cls;

    assign in_stall = full;
    assign push     = in_valid && !full;

    // drive gain in q4.12 with round half up, floored
    assign drv_prod = sample_in * signed'({1'b0, cfg.drive});
    assign drv_sum  = drv_prod + 33'(ROUND_Q12);

    always_comb
    begin
        unique case (cfg.mode)
            MODE_SOFT: cls = CLS_SOFT;
            MODE_HARD: cls = CLS_HARD;
            MODE_FOLD: cls = CLS_FOLD;
            default:   cls = CLS_MUTE;
        endcase
    end

    assign item.x   = sample_in;
    assign item.d   = D_W'(drv_sum >>> 12);
    assign item.cls = cls;

endmodule

// ===== design/wsd_queue.sv =====
`include "waveshaping_distortion_top_macros.svh"

module wsd_queue
    import wsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    item_t             mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `WSD_ASSERT(q_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `WSD_ASSERT_IMPLY(q_pop_nonempty, pop, !empty)
    `WSD_ASSERT_NEXT(q_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== design/wsd_back.sv =====
`include "waveshaping_distortion_top_macros.svh"

module wsd_back
    import wsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  item_t                      head,
    input  logic                       empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        cls_t                       cls;
        logic                       neg;
        logic                       sat;
        logic signed [SAMPLE_W-1:0] y;
    } side_t;

    localparam int ST_B  = DIV1_STEPS + 1;
    localparam int ST_C  = ST_B + 1;
    localparam int ST_D  = ST_C + 1;
    localparam int ST_E  = ST_D + 1;
    localparam int ST_F  = ST_E + 1;
    localparam int ST_G  = ST_F + 1;
    localparam int ST_H  = ST_G + DIV2_STEPS + 1;
    localparam int ST_M1 = ST_H + 1;
    localparam int ST_M2 = ST_M1 + 1;
    localparam int ST_M3 = ST_M2 + 1;
    localparam int ST_O  = ST_M3 + 1;
    localparam int NSTG  = ST_O + 1;

    logic            en;
    logic [NSTG-1:0] vld_reg;
    side_t           side_reg [0:NSTG-1];
    side_t           side_a_next;
    side_t           side_b_next;
    side_t           side_g_next;
    side_t           side_h_next;

    // stage a
    logic [THR_W-1:0]           thr;
    logic signed [D_W-1:0]      d;
    logic [D_W-1:0]             mag_a;
    logic [17:0]                thr5;
    logic signed [D_W:0]        n_a;
    logic [D_W-1:0]             na_a;
    logic signed [D_W-1:0]      thr_s;
    logic signed [D_W-1:0]      thr_neg;
    logic signed [SAMPLE_W-1:0] y_hard;
    logic [DIV1_W-1:0]          dd_a;
    logic [DIV1_VW-1:0]         dv_a;

    // shared quotient / remainder divider
    logic [DIV1_VW-1:0] r1_reg  [0:DIV1_STEPS];
    logic [DIV1_W-1:0]  q1_reg  [0:DIV1_STEPS];
    logic [DIV1_VW-1:0] r1_next [1:DIV1_STEPS];
    logic [DIV1_W-1:0]  q1_next [1:DIV1_STEPS];

    // tanh polynomial chain
    logic [14:0]        u_b_reg, u_c_reg, u_d_reg, u_e_reg;
    logic [16:0]        p1_b_reg, p1_c_reg, p1_d_reg;
    logic [21:0]        p2_c_reg, p2_d_reg;
    logic [25:0]        p3_d_reg;
    logic [31:0]        num_e_reg;
    logic [DIV2_VW-1:0] den_e_reg, den_f_reg;
    logic [46:0]        prod_f_reg;
    logic [29:0]        uu;
    logic [33:0]        p1sq;
    logic [38:0]        p21;
    logic signed [17:0] fold_diff;
    logic [16:0]        fold_abs;
    logic signed [17:0] fold_y;
    logic [49:0]        nn_g;
    logic               ovf_g;

    // tanh quotient divider
    logic [DIV2_VW-1:0] r2_reg   [0:DIV2_STEPS];
    logic [15:0]        q2_reg   [0:DIV2_STEPS];
    logic [DIV2_VW-1:0] den_reg  [0:DIV2_STEPS];
    logic [DIV2_VW-1:0] r2_next  [1:DIV2_STEPS];
    logic [15:0]        q2_next  [1:DIV2_STEPS];

    // output scaling and blend
    logic [15:0]                tq;
    logic [30:0]                ys_full;
    logic signed [SAMPLE_W-1:0] ys;
    logic signed [32:0]         wp;
    logic signed [20:0]         w_reg;
    logic signed [23:0]         a1_reg;
    logic signed [28:0]         a2_reg;
    logic signed [29:0]         s_sum;
    logic [22:0]                sp_reg;
    logic                       hi_reg;
    logic                       lo_reg;
    logic [46:0]                qq;
    logic [15:0]                qd;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic signed [SAMPLE_W-1:0] sample_out_next;

    // whole back pipeline holds while the result is not taken
    assign en        = !(vld_reg[NSTG-1] && out_stall);
    assign pop       = en && !empty;
    assign out_valid = vld_reg[NSTG-1];
    assign sample_out = sample_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], pop};
        end
    end

    // stage a: magnitudes, hard clip and divider operands
    assign thr     = cfg.thr;
    assign d       = head.d;
    assign mag_a   = d[D_W-1] ? D_W'(-d) : D_W'(d);
    assign thr5    = {1'b0, thr, 2'b00} + 18'(thr);
    assign n_a     = (D_W+1)'(d) - (D_W+1)'(signed'({1'b0, thr}));
    assign na_a    = n_a[D_W] ? D_W'(-n_a) : D_W'(n_a);
    assign thr_s   = D_W'(signed'({1'b0, thr}));
    assign thr_neg = -thr_s;

    always_comb
    begin
        priority if (d > thr_s)
        begin
            y_hard = SAMPLE_W'(thr_s);
        end
        else if (d < thr_neg)
        begin
            y_hard = SAMPLE_W'(thr_neg);
        end
        else
        begin
            y_hard = SAMPLE_W'(d);
        end
    end

    always_comb
    begin
        if (head.cls == CLS_FOLD)
        begin
            dd_a = DIV1_W'(na_a);
            dv_a = {thr, 2'b00};
        end
        else
        begin
            dd_a = {mag_a[17:0], 12'b0};
            dv_a = DIV1_VW'(thr);
        end
        side_a_next.x   = head.x;
        side_a_next.cls = head.cls;
        side_a_next.neg = d[D_W-1];
        side_a_next.sat = mag_a >= D_W'(thr5);
        side_a_next.y   = y_hard;
    end

    // one quotient bit per stage; divisor follows from the item class
    always_comb
    begin
        logic [DIV1_VW:0]   wide;
        logic [DIV1_VW-1:0] dv;
        logic               ge;
        for (int k = 1; k <= DIV1_STEPS; k++)
        begin
            dv   = (side_reg[k-1].cls == CLS_FOLD) ? {thr, 2'b00} : DIV1_VW'(thr);
            wide = {r1_reg[k-1], q1_reg[k-1][DIV1_W-1]};
            ge   = wide >= {1'b0, dv};
            r1_next[k] = ge ? DIV1_VW'(wide - {1'b0, dv}) : wide[DIV1_VW-1:0];
            q1_next[k] = {q1_reg[k-1][DIV1_W-2:0], ge};
        end
    end

    // stage b: fold from remainder, square of u
    assign uu        = 30'(q1_reg[DIV1_STEPS][14:0]) * 30'(q1_reg[DIV1_STEPS][14:0]);
    assign fold_diff = signed'({1'b0, r1_reg[DIV1_STEPS]}) - signed'({2'b0, thr, 1'b0});
    assign fold_abs  = fold_diff[17] ? 17'(-fold_diff) : 17'(fold_diff);
    assign fold_y    = signed'({1'b0, fold_abs}) - signed'({3'b0, thr});

    always_comb
    begin
        side_b_next = side_reg[ST_B-1];
        if (side_reg[ST_B-1].cls == CLS_FOLD)
        begin
            side_b_next.y = SAMPLE_W'(fold_y);
        end
    end

    assign p1sq = 34'(p1_b_reg) * 34'(p1_b_reg);
    assign p21  = 39'(p2_c_reg) * 39'(p1_c_reg);

    // stage g: scaled numerator, overflow of a quotient past 16 bits
    assign nn_g  = {prod_f_reg, 3'b000};
    assign ovf_g = {1'b0, nn_g[49:16]} >= den_f_reg;

    always_comb
    begin
        side_g_next = side_reg[ST_G-1];
        side_g_next.sat = side_reg[ST_G-1].sat || ovf_g;
    end

    always_comb
    begin
        logic [DIV2_VW:0] wide;
        logic             ge;
        for (int k = 1; k <= DIV2_STEPS; k++)
        begin
            wide = {r2_reg[k-1], q2_reg[k-1][15]};
            ge   = wide >= {1'b0, den_reg[k-1]};
            r2_next[k] = ge ? DIV2_VW'(wide - {1'b0, den_reg[k-1]}) : wide[DIV2_VW-1:0];
            q2_next[k] = {q2_reg[k-1][14:0], ge};
        end
    end

    // stage h: tanh capped at one, scaled by threshold
    always_comb
    begin
        if (side_reg[ST_H-1].sat || q2_reg[DIV2_STEPS] > 16'(T_ONE))
        begin
            tq = 16'(T_ONE);
        end
        else
        begin
            tq = q2_reg[DIV2_STEPS];
        end
    end

    assign ys_full = 31'(thr) * 31'(tq);
    assign ys      = side_reg[ST_H-1].neg ? -signed'(ys_full[30:15]) : signed'(ys_full[30:15]);

    always_comb
    begin
        side_h_next = side_reg[ST_H-1];
        if (side_reg[ST_H-1].cls == CLS_SOFT)
        begin
            side_h_next.y = ys;
        end
    end

    assign wp    = side_reg[ST_H].y * signed'({1'b0, cfg.og});
    assign s_sum = 30'(a1_reg) + 30'(a2_reg) + 30'(MIX_FULL / 2);
    assign qq    = 47'(sp_reg) * 47'(RECIP_100);
    assign qd    = qq[45:30];

    always_comb
    begin
        priority if (side_reg[ST_M3].cls == CLS_MUTE)
        begin
            sample_out_next = '0;
        end
        else if (hi_reg)
        begin
            sample_out_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (lo_reg)
        begin
            sample_out_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sample_out_next = {~qd[15], qd[14:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_a_next;
            for (int i = 1; i < NSTG; i++)
            begin
                if (i != ST_B && i != ST_G && i != ST_H)
                begin
                    side_reg[i] <= side_reg[i-1];
                end
            end
            side_reg[ST_B] <= side_b_next;
            side_reg[ST_G] <= side_g_next;
            side_reg[ST_H] <= side_h_next;

            r1_reg[0] <= '0;
            q1_reg[0] <= dd_a;
            for (int k = 1; k <= DIV1_STEPS; k++)
            begin
                r1_reg[k] <= r1_next[k];
                q1_reg[k] <= q1_next[k];
            end

            u_b_reg  <= q1_reg[DIV1_STEPS][14:0];
            p1_b_reg <= uu[28:12];
            u_c_reg  <= u_b_reg;
            p1_c_reg <= p1_b_reg;
            p2_c_reg <= p1sq[33:12];
            u_d_reg  <= u_c_reg;
            p1_d_reg <= p1_c_reg;
            p2_d_reg <= p2_c_reg;
            p3_d_reg <= p21[37:12];
            u_e_reg  <= u_d_reg;
            num_e_reg <= 32'(TANH_K0) + 32'(p1_d_reg) * 32'(TANH_N1)
                       + 32'(p2_d_reg) * 32'(TANH_N2) + 32'(p3_d_reg);
            den_e_reg <= DIV2_VW'(TANH_K0) + DIV2_VW'(p1_d_reg) * DIV2_VW'(TANH_D1)
                       + DIV2_VW'(p2_d_reg) * DIV2_VW'(TANH_D2)
                       + DIV2_VW'(p3_d_reg) * DIV2_VW'(TANH_D3);
            prod_f_reg <= 47'(u_e_reg) * 47'(num_e_reg);
            den_f_reg  <= den_e_reg;

            r2_reg[0]  <= ovf_g ? '0 : {1'b0, nn_g[49:16]};
            q2_reg[0]  <= nn_g[15:0];
            den_reg[0] <= den_f_reg;
            for (int k = 1; k <= DIV2_STEPS; k++)
            begin
                r2_reg[k]  <= r2_next[k];
                q2_reg[k]  <= q2_next[k];
                den_reg[k] <= den_reg[k-1];
            end

            w_reg  <= 21'((wp + 33'(ROUND_Q12)) >>> 12);
            a1_reg <= side_reg[ST_M1].x * signed'({1'b0, 7'(MIX_FULL) - cfg.mix});
            a2_reg <= w_reg * signed'({1'b0, cfg.mix});
            sp_reg <= 23'(s_sum + 30'(SAT_SPAN));
            hi_reg <= s_sum >= 30'(SAT_SPAN);
            lo_reg <= s_sum < -30'(SAT_SPAN);
            sample_out_reg <= sample_out_next;
        end
    end

    `WSD_ASSERT_NEXT(bk_freeze, !en, $stable(vld_reg))
    `WSD_ASSERT_IMPLY(bk_mute_zero, vld_reg[NSTG-1] && side_reg[NSTG-1].cls == CLS_MUTE, sample_out_reg == '0)
    `WSD_ASSERT_NEXT(bk_out_hold, out_valid && out_stall, out_valid && $stable(sample_out_reg))

endmodule

// ===== verif/tb_waveshaping_distortion_top.sv =====
`timescale 1ns / 100ps

module tb_waveshaping_distortion_top;
    import wsd_pkg::*;

    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 200;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample_out;

    // shadow copy of the register file
    logic [MODE_W-1:0] sh_mode;
    logic [GAIN_W-1:0] sh_drive;
    logic [THR_W-1:0]  sh_thr;
    logic [MIX_W-1:0]  sh_mix;
    logic [GAIN_W-1:0] sh_og;

    logic signed [SAMPLE_W-1:0] pending_samples[$];
    logic signed [SAMPLE_W-1:0] expected_samples[$];

    int  n_errors;
    int  n_checked;
    bit  hold_off;
    int  hold_cycles;
    int  sent_items;
    bit  in_accepted;

    waveshaping_distortion_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // floor division for signed 64-bit values
    function automatic longint floor_div(longint n, longint dv);
        longint q;
        q = n / dv;
        if ((n % dv) != 0 && n < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    // tanh in q15 from the rational continued-fraction form, u in q12
    function automatic longint tanh_q15(longint unsigned u);
        longint unsigned x2;
        longint unsigned x4;
        longint unsigned x6;
        longint unsigned num;
        longint unsigned den;
        longint unsigned t;
        if (u >= 5 * 4096)
        begin
            return 32768;
        end
        x2  = (u * u) >> 12;
        x4  = (x2 * x2) >> 12;
        x6  = (x4 * x2) >> 12;
        num = 135135 * 4096 + 17325 * x2 + 378 * x4 + x6;
        den = 135135 * 4096 + 62370 * x2 + 3150 * x4 + 28 * x6;
        t   = (u * num * 8) / den;
        if (t > 32768)
        begin
            t = 32768;
        end
        return longint'(t);
    endfunction

    // drive, shape, output gain, dry/wet blend and saturate
    function automatic logic signed [SAMPLE_W-1:0] shape_sample(logic signed [SAMPLE_W-1:0] s);
        longint x;
        longint t;
        longint m;
        longint d;
        longint y;
        longint w;
        longint r;
        longint mag;
        longint u;
        longint md;
        x = longint'(s);
        t = (sh_thr == 0) ? 1 : longint'(sh_thr);
        m = (sh_mix > MIX_FULL) ? MIX_FULL : longint'(sh_mix);
        if (sh_mode == MODE_OFF)
        begin
            return '0;
        end
        d = floor_div(x * longint'(sh_drive) + ROUND_Q12, UNITY_GAIN);
        if (sh_mode == MODE_SOFT)
        begin
            mag = (d < 0) ? -d : d;
            u   = (mag * 4096) / t;
            if (u > 5 * 4096)
            begin
                u = 5 * 4096;
            end
            y = (t * tanh_q15(u)) >>> 15;
            if (d < 0)
            begin
                y = -y;
            end
        end
        else if (sh_mode == MODE_HARD)
        begin
            y = (d > t) ? t : ((d < -t) ? -t : d);
        end
        else
        begin
            // fold: remainder truncates toward zero
            md = (d - t) % (4 * t);
            md = (md < 0) ? -md : md;
            md = md - 2 * t;
            md = (md < 0) ? -md : md;
            y  = md - t;
        end
        w = floor_div(y * longint'(sh_og) + ROUND_Q12, UNITY_GAIN);
        r = floor_div(x * (100 - m) + w * m + 50, 100);
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            return 0;
        end
        else if (p < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // driver: offers items from the pending queue, prediction made on accept
    int in_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
            in_gap    <= 0;
        end
        else if (in_valid && !in_accepted)
        begin
            // stalled item holds
        end
        else if (in_gap > 0)
        begin
            in_valid <= 1'b0;
            in_gap   <= in_gap - 1;
        end
        else if (pending_samples.size() > 0)
        begin
            in_valid  <= 1'b1;
            sample_in <= pending_samples.pop_front();
            in_gap    <= gap_len();
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // accept point for the input channel
    always @(posedge clk)
    begin
        in_accepted <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_samples.push_back(shape_sample(sample_in));
            sent_items <= sent_items + 1;
        end
    end

    // receiver stall: random gaps plus an optional long hold-off
    int out_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            out_gap     <= 0;
            hold_cycles <= 0;
        end
        else if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_off)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= HOLD_CYCLES;
        end
        else if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap   <= out_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            out_gap   <= gap_len();
        end
    end

    // monitor: each output item against the oldest prediction
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] exp_s;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: unexpected item, actual %0d", sample_out);
                n_errors++;
            end
            else
            begin
                exp_s = expected_samples.pop_front();
                n_checked++;
                if (sample_out !== exp_s)
                begin
                    $error("sample_out: expected %0d actual %0d", exp_s, sample_out);
                    n_errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        // shadow the written value; zero threshold and mix clamp are applied in shape_sample
        case (idx)
            REG_MODE:     sh_mode  = val[MODE_W-1:0];
            REG_DRIVE:    sh_drive = val;
            REG_THRESH:   sh_thr   = val[THR_W-1:0];
            REG_MIX:      sh_mix   = val[MIX_W-1:0];
            REG_OUT_GAIN: sh_og    = val;
            default:      ;
        endcase
    endtask

    task automatic set_all(input logic [MODE_W-1:0] md, input int dr, input int th,
                           input int mx, input int og);
        write_reg(REG_MODE, CFG_DATA_W'(md));
        write_reg(REG_DRIVE, CFG_DATA_W'(dr));
        write_reg(REG_THRESH, CFG_DATA_W'(th));
        write_reg(REG_MIX, CFG_DATA_W'(mx));
        write_reg(REG_OUT_GAIN, CFG_DATA_W'(og));
    endtask

    // wait until every item is through, then let the pipe empty
    task automatic wait_idle();
        while (pending_samples.size() > 0 || in_valid || expected_samples.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
        begin
            return 16'sh7fff;
        end
        if (p == 1)
        begin
            return 16'sh8000;
        end
        if (p < 4)
        begin
            return SAMPLE_W'($urandom_range(0, 600)) - 16'sd300;
        end
        return SAMPLE_W'($urandom());
    endfunction

    task automatic push_random(input int count);
        repeat (count) pending_samples.push_back(rand_sample());
    endtask

    function automatic int rand_thr();
        int p;
        p = $urandom_range(0, 5);
        if (p == 0)
        begin
            return 1;
        end
        if (p == 1)
        begin
            return 32767;
        end
        if (p == 2)
        begin
            return $urandom_range(1, 200);
        end
        return $urandom_range(1, 32767);
    endfunction

    initial
    begin
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        hold_off   = 1'b0;
        n_errors   = 0;
        n_checked  = 0;
        sent_items = 0;
        sh_mode    = MODE_SOFT;
        sh_drive   = GAIN_W'(UNITY_GAIN);
        sh_thr     = 15'd32767;
        sh_mix     = 7'd100;
        sh_og      = GAIN_W'(UNITY_GAIN);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, field extremes
        pending_samples = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                            16'sh4000, 16'shc000};
        wait_idle();

        // each mode with small threshold and high drive, fold wraps many times
        for (int md = 0; md < 4; md++)
        begin
            set_all(md[MODE_W-1:0], 65535, 100, 100, 65535);
            pending_samples = '{16'sh7fff, 16'sh8000, 16'sd99, -16'sd7, 16'sh5555};
            wait_idle();
        end

        // zero threshold, mix above one hundred, out-of-range index
        set_all(MODE_FOLD, 4096, 0, 127, 4096);
        write_reg(3'd5, 16'hffff);
        write_reg(3'd7, 16'h1234);
        pending_samples = '{16'sd3, -16'sd3, 16'sh7fff};
        wait_idle();

        // zero gains, dry only
        set_all(MODE_HARD, 0, 32767, 0, 0);
        pending_samples = '{16'sh7fff, 16'sh8000, 16'sd1234};
        wait_idle();

        // long receiver hold-off so the front queue fills and in_stall rises
        set_all(MODE_SOFT, 8192, 16000, 50, 4096);
        hold_off = 1'b1;
        push_random(40);
        @(posedge clk iff hold_cycles > 0);
        hold_off = 1'b0;
        wait_idle();

        // random phases across register settings
        for (int ph = 0; ph < 12; ph++)
        begin
            set_all(MODE_W'($urandom_range(0, 3)),
                    (ph % 4 == 0) ? 65535 : $urandom_range(0, 65535),
                    rand_thr(), (ph % 5 == 0) ? 0 : $urandom_range(0, 127),
                    (ph % 3 == 0) ? 0 : $urandom_range(0, 65535));
            push_random(55);
            wait_idle();
        end

        $display("covered %0d samples in %0d checks over all shape modes,", sent_items,
                 n_checked);
        $display("gain, threshold and mix extremes, and a full input queue");
        if (n_errors == 0)
        begin
            $display("waveshaping_distortion_top: match");
        end
        else
        begin
            $display("waveshaping_distortion_top: mismatch");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("waveshaping_distortion_top: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/wsd_pkg.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/waveshaping_distortion_top.sv
verif/tb_waveshaping_distortion_top.sv
